>>> hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define SFD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next cycle
`define SFD_ASSERT_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error(msg);

`endif

>>> hw/rtl/sfd_pkg.sv
// ---------------------------------------------------------------------------
// sfd_pkg
// shared types, codes and constants of the serial frame deframer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

   // framing constants
   localparam logic [7:0]  HDR_BYTE     = 8'hFF;
   localparam logic [7:0]  STUFF_BYTE   = 8'h55;
   localparam logic [15:0] LEN_OVERHEAD = 16'd5;

   // kept-byte counts that mark the header field ends, the stuffing start and the payload offset
   localparam logic [15:0] CNT_HDR_END  = 16'd2;
   localparam logic [15:0] CNT_LEN_STUF = 16'd3;
   localparam logic [15:0] CNT_LEN_END  = 16'd4;
   localparam logic [15:0] CNT_FLG_END  = 16'd8;
   localparam logic [15:0] CNT_PAY_OFS  = 16'd3;

   // result kinds
   localparam logic [2:0] KIND_PAYLOAD = 3'd0;
   localparam logic [2:0] KIND_GOOD    = 3'd1;
   localparam logic [2:0] KIND_BADSUM  = 3'd2;
   localparam logic [2:0] KIND_HDRERR  = 3'd3;
   localparam logic [2:0] KIND_LENERR  = 3'd4;

   // register map
   localparam int          CSR_ADDR_W       = 3;
   localparam logic        CSR_IDX_MAX_LEN  = 1'b0;
   localparam logic [15:0] MAX_LEN_RESET    = 16'd256;

   // result queue
   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic [6:0] {
      PH_HDR = 7'b0000001,
      PH_LEN = 7'b0000010,
      PH_CMD = 7'b0000100,
      PH_SEQ = 7'b0001000,
      PH_FLG = 7'b0010000,
      PH_PAY = 7'b0100000,
      PH_SUM = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  data_byte;
      logic [7:0]  command_code;
      logic [7:0]  sequence_number;
      logic [15:0] flag_word;
      logic [15:0] payload_length;
   } rsp_type;

endpackage

`default_nettype wire

>>> hw/rtl/sfd_channels.sv
// ---------------------------------------------------------------------------
// sfd channels
// valid/ready channel interfaces for requests and results
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  data_byte;
   logic [7:0]  command_code;
   logic [7:0]  sequence_number;
   logic [15:0] flag_word;
   logic [15:0] payload_length;

   modport source (output valid, output kind, output data_byte, output command_code,
                   output sequence_number, output flag_word, output payload_length,
                   input ready);
   modport sink   (input valid, input kind, input data_byte, input command_code,
                   input sequence_number, input flag_word, input payload_length,
                   output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sfd_parser.sv
// ---------------------------------------------------------------------------
// sfd_parser
// front end: destuffing, field capture and result classification per byte
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sfd_parser (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           byte_fire,
   input  wire logic [7:0]     rx_byte,
   input  wire logic [15:0]    max_len,
   output logic                ev_valid,
   output sfd_pkg::rsp_type    ev
);
   import sfd_pkg::*;

   phase_type   phase_ff,  phase_in;
   logic [15:0] count_ff,  count_in;
   logic [7:0]  prev_ff,   prev_in;
   logic [15:0] len_ff,    len_in;
   logic [7:0]  cmd_ff,    cmd_in;
   logic [7:0]  seq_ff,    seq_in;
   logic [15:0] flg_ff,    flg_in;
   logic [7:0]  sum_ff,    sum_in;

   logic filtering;
   logic drop;
   logic restart;

   assign filtering = (phase_ff != PH_HDR) &&
                      !((phase_ff == PH_LEN) && (count_ff < CNT_LEN_STUF));
   assign drop      = filtering && (prev_ff == HDR_BYTE) && (rx_byte == STUFF_BYTE);

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      prev_in  = prev_ff;
      len_in   = len_ff;
      cmd_in   = cmd_ff;
      seq_in   = seq_ff;
      flg_in   = flg_ff;
      sum_in   = sum_ff;
      restart  = 1'b0;
      ev_valid = 1'b0;
      ev       = '0;

      if (byte_fire && drop) begin
         prev_in = '0;
      end else if (byte_fire) begin
         count_in = count_ff + 16'd1;
         if (phase_ff != PH_HDR) prev_in = rx_byte;
         if ((phase_ff != PH_HDR) && (phase_ff != PH_SUM)) sum_in = sum_ff + rx_byte;

         unique case (phase_ff)
            PH_HDR: begin
               if (rx_byte != HDR_BYTE) begin
                  restart  = 1'b1;
                  ev_valid = 1'b1;
                  ev.kind  = KIND_HDRERR;
               end else if (count_in == CNT_HDR_END) begin
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               len_in = {len_ff[7:0], rx_byte};
               if (count_in == CNT_LEN_END) begin
                  if ((len_in < LEN_OVERHEAD) || ((len_in - LEN_OVERHEAD) > max_len)) begin
                     restart  = 1'b1;
                     ev_valid = 1'b1;
                     ev.kind  = KIND_LENERR;
                  end else begin
                     phase_in = PH_CMD;
                  end
               end
            end
            PH_CMD: begin
               cmd_in   = rx_byte;
               phase_in = PH_SEQ;
            end
            PH_SEQ: begin
               seq_in   = rx_byte;
               phase_in = PH_FLG;
            end
            PH_FLG: begin
               flg_in = {flg_ff[7:0], rx_byte};
               if (count_in == CNT_FLG_END) begin
                  phase_in = (len_ff > LEN_OVERHEAD) ? PH_PAY : PH_SUM;
               end
            end
            PH_PAY: begin
               if ((count_in - CNT_PAY_OFS) == len_ff) phase_in = PH_SUM;
               ev_valid     = 1'b1;
               ev.kind      = KIND_PAYLOAD;
               ev.data_byte = rx_byte;
            end
            PH_SUM: begin
               ev_valid           = 1'b1;
               ev.kind            = (rx_byte == sum_ff) ? KIND_GOOD : KIND_BADSUM;
               ev.command_code    = cmd_ff;
               ev.sequence_number = seq_ff;
               ev.flag_word       = flg_ff;
               ev.payload_length  = len_ff - LEN_OVERHEAD;
               restart            = 1'b1;
            end
            default: begin
               restart = 1'b1;
            end
         endcase
      end

      if (restart) begin
         phase_in = PH_HDR;
         count_in = '0;
         prev_in  = '0;
         len_in   = '0;
         cmd_in   = '0;
         seq_in   = '0;
         flg_in   = '0;
         sum_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR;
         count_ff <= '0;
         prev_ff  <= '0;
         len_ff   <= '0;
         cmd_ff   <= '0;
         seq_ff   <= '0;
         flg_ff   <= '0;
         sum_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         prev_ff  <= prev_in;
         len_ff   <= len_in;
         cmd_ff   <= cmd_in;
         seq_ff   <= seq_in;
         flg_ff   <= flg_in;
         sum_ff   <= sum_in;
      end
   end

   // a frame verdict always leaves the parser waiting for a header
   `SFD_ASSERT_NEXT(a_end_restarts,
      ev_valid && ((ev.kind == KIND_GOOD) || (ev.kind == KIND_BADSUM)),
      phase_ff == PH_HDR, "parser not back in header phase after frame end")

   // a dropped stuffing byte never yields a result
   `SFD_ASSERT(a_drop_silent, !(byte_fire && drop && ev_valid),
      "result produced for a stuffing byte")

endmodule

`default_nettype wire

>>> hw/rtl/sfd_queue.sv
// ---------------------------------------------------------------------------
// sfd_queue
// short result queue between parser and result port, registered entries
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sfd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire sfd_pkg::rsp_type  push_data,
   output logic                   full,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output sfd_pkg::rsp_type       out_data
);
   import sfd_pkg::*;

   rsp_type             mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff,  count_in;
   logic                pop;

   assign full      = (count_ff == QCNT_W'(QDEPTH));
   assign out_valid = (count_ff != '0);
   assign pop       = out_valid && out_ready;
   assign out_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `SFD_ASSERT(a_no_overflow, !(push && full && !pop), "push into a full result queue")
   `SFD_ASSERT(a_count_bound, count_ff <= QCNT_W'(QDEPTH), "queue count beyond depth")
   `SFD_ASSERT_NEXT(a_count_up, push && !pop, count_ff == $past(count_ff) + 1'b1,
      "queue count did not follow a push")

endmodule

`default_nettype wire

>>> hw/rtl/serial_frame_deframer.sv
// ---------------------------------------------------------------------------
// serial_frame_deframer
// parses byte-stuffed serial frames with an additive checksum into results
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// channel   dir    handshake        payload
// req_ch    in     valid / ready    rx_byte
// rsp_ch    out    valid / ready    kind, data_byte, command_code, sequence_number,
//                                   flag_word, payload_length
// csr_*     in     apb write/read   max_payload_len at byte address 0
//
// one request per cycle while the result queue has room; the parser updates its state in the accepting cycle
// each result is written into a registered two-entry queue and is offered on rsp_ch from there
// req_ch.ready drops only while the result queue is full
// reset is synchronous and clears the parser state, the queue and max_payload_len (256)

module serial_frame_deframer (
   input  wire logic                          clock,
   input  wire logic                          reset,
   sfd_req_if.sink                            req_ch,
   sfd_rsp_if.source                          rsp_ch,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [sfd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                   csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import sfd_pkg::*;

   logic [15:0] max_len_ff, max_len_in;
   logic        csr_wr;
   logic        q_full;
   logic        byte_fire;
   logic        ev_valid;
   rsp_type     ev;
   rsp_type     q_data;

   // configuration register, ready is always high
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      max_len_in = max_len_ff;
      if (csr_wr && (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_MAX_LEN)) begin
         max_len_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) max_len_ff <= MAX_LEN_RESET;
      else       max_len_ff <= max_len_in;
   end

   // only the first register exists; addresses with the top address bit set read as zero
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_MAX_LEN) ?
                       {16'd0, max_len_ff} : 32'd0;

   // front end takes a request whenever the queue has room for its result
   assign req_ch.ready = !q_full;
   assign byte_fire    = req_ch.valid && req_ch.ready;

   sfd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .byte_fire (byte_fire),
      .rx_byte   (req_ch.rx_byte),
      .max_len   (max_len_ff),
      .ev_valid  (ev_valid),
      .ev        (ev)
   );

   // back end: queued results drain to the result port on their own
   sfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (ev_valid),
      .push_data (ev),
      .full      (q_full),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (q_data)
   );

   assign rsp_ch.kind            = q_data.kind;
   assign rsp_ch.data_byte       = q_data.data_byte;
   assign rsp_ch.command_code    = q_data.command_code;
   assign rsp_ch.sequence_number = q_data.sequence_number;
   assign rsp_ch.flag_word       = q_data.flag_word;
   assign rsp_ch.payload_length  = q_data.payload_length;

endmodule

`default_nettype wire

>>> dv/serial_frame_deframer_tb.sv
// ---------------------------------------------------------------------------
// serial_frame_deframer_tb
// drives received bytes into the deframer, predicts every result from an
// in-bench parser and compares each result field by field; covers header,
// length and checksum faults, byte stuffing, register settings and stalls
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_frame_deframer_tb;
   import sfd_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] MAX_LEN_ADDR = CSR_ADDR_W'(4 * int'(CSR_IDX_MAX_LEN));

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   sfd_req_if req_ch ();
   sfd_rsp_if rsp_ch ();

   serial_frame_deframer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // parser shadow state, updated once per accepted request
   phase_type   st_phase;
   logic [15:0] st_count;
   logic [7:0]  st_prev;
   logic [15:0] st_len;
   logic [7:0]  st_cmd;
   logic [7:0]  st_seq;
   logic [15:0] st_flags;
   logic [7:0]  st_sum;
   logic [15:0] st_max_len;

   rsp_type expected_results[$];

   int  fail_count  = 0;
   int  bytes_sent  = 0;
   bit  req_gaps_on = 1'b1;
   bit  rsp_gaps_on = 1'b1;
   int  hold_request = 0;

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------

   // back to header search, frame fields cleared, register kept
   task automatic clear_parser();
      st_phase = PH_HDR;
      st_count = '0;
      st_prev  = '0;
      st_len   = '0;
      st_cmd   = '0;
      st_seq   = '0;
      st_flags = '0;
      st_sum   = '0;
   endtask

   // advance the shadow parser by one byte and queue the result it causes
   task automatic parse_rx_byte(input logic [7:0] b);
      rsp_type r;
      logic    has_r;
      logic    filtering;
      r     = '0;
      has_r = 1'b0;
      // stuffing is recognized from the second length byte onward
      filtering = (st_phase != PH_HDR && st_phase != PH_LEN) ||
                  (st_phase == PH_LEN && st_count >= CNT_LEN_STUF);
      if (filtering && st_prev == HDR_BYTE && b == STUFF_BYTE) begin
         // dropped: not counted, not summed, and it breaks the 0xff pairing
         st_prev = '0;
         return;
      end
      st_count = st_count + 16'd1;
      if (st_phase != PH_HDR) st_prev = b;
      if (st_phase != PH_HDR && st_phase != PH_SUM) st_sum = st_sum + b;
      case (st_phase)
         PH_HDR: begin
            if (b != HDR_BYTE) begin
               clear_parser();
               r.kind = KIND_HDRERR;
               has_r  = 1'b1;
            end else if (st_count == CNT_HDR_END) begin
               st_phase = PH_LEN;
            end
         end
         PH_LEN: begin
            st_len = {st_len[7:0], b};
            if (st_count == CNT_LEN_END) begin
               if (st_len < LEN_OVERHEAD || (st_len - LEN_OVERHEAD) > st_max_len) begin
                  clear_parser();
                  r.kind = KIND_LENERR;
                  has_r  = 1'b1;
               end else begin
                  st_phase = PH_CMD;
               end
            end
         end
         PH_CMD: begin
            st_cmd   = b;
            st_phase = PH_SEQ;
         end
         PH_SEQ: begin
            st_seq   = b;
            st_phase = PH_FLG;
         end
         PH_FLG: begin
            st_flags = {st_flags[7:0], b};
            // an empty payload goes straight to the checksum
            if (st_count == CNT_FLG_END) st_phase = (st_len > LEN_OVERHEAD) ? PH_PAY : PH_SUM;
         end
         PH_PAY: begin
            if (st_count - CNT_PAY_OFS == st_len) st_phase = PH_SUM;
            r.kind      = KIND_PAYLOAD;
            r.data_byte = b;
            has_r       = 1'b1;
         end
         PH_SUM: begin
            r.kind            = (b == st_sum) ? KIND_GOOD : KIND_BADSUM;
            r.command_code    = st_cmd;
            r.sequence_number = st_seq;
            r.flag_word       = st_flags;
            r.payload_length  = st_len - LEN_OVERHEAD;
            has_r             = 1'b1;
            clear_parser();
         end
         default: clear_parser();
      endcase
      if (has_r) expected_results.push_back(r);
   endtask

   // ------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      end
   endtask

   // every accepted result is matched against the oldest prediction
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            fail_count++;
            $error("result kind %0d with nothing expected", rsp_ch.kind);
         end else begin
            want = expected_results.pop_front();
            check_field("kind", want.kind, rsp_ch.kind);
            check_field("data_byte", want.data_byte, rsp_ch.data_byte);
            check_field("command_code", want.command_code, rsp_ch.command_code);
            check_field("sequence_number", want.sequence_number, rsp_ch.sequence_number);
            check_field("flag_word", want.flag_word, rsp_ch.flag_word);
            check_field("payload_length", want.payload_length, rsp_ch.payload_length);
         end
      end
   end

   // ------------------------------------------------------------------
   // idling and the result side
   // ------------------------------------------------------------------

   // mostly no gap, sometimes a short one, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // sole driver of rsp ready; a hold-off request is counted down here
   initial begin : result_sink
      int gap;
      int hold_left;
      gap       = 0;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (!rsp_gaps_on) begin
            rsp_ch.ready <= 1'b1;
         end else if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            gap--;
         end else begin
            rsp_ch.ready <= 1'b1;
            gap = pick_gap();
         end
      end
   end

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------

   // offer one byte, hold it until accepted, then predict its effect;
   // valid is lowered only during a picked gap, so with no gap back-to-back requests go through without one
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      parse_rx_byte(b);
      bytes_sent++;
   endtask

   // header, fields, payload and checksum; 0x55 is stuffed after a kept 0xff where needed or by stuff_pct;
   // raw skips the stuffing that the data needs, cut_at limits the kept bytes sent
   task automatic send_frame(input logic [15:0] lenf, input logic [7:0] cmd,
                             input logic [7:0] seq, input logic [15:0] flags,
                             input logic [7:0] pay[$], input bit bad_sum, input bit raw,
                             input int stuff_pct, input int cut_at);
      logic [7:0] kept[$];
      logic [7:0] csum;
      int         last;
      kept.push_back(lenf[15:8]);
      kept.push_back(lenf[7:0]);
      kept.push_back(cmd);
      kept.push_back(seq);
      kept.push_back(flags[15:8]);
      kept.push_back(flags[7:0]);
      foreach (pay[i]) kept.push_back(pay[i]);
      csum = '0;
      foreach (kept[i]) csum = csum + kept[i];
      if (bad_sum) csum = csum + 8'($urandom_range(1, 255));
      kept.push_back(csum);
      last = (cut_at < 0 || cut_at > kept.size()) ? kept.size() : cut_at;
      send_byte(HDR_BYTE);
      send_byte(HDR_BYTE);
      for (int i = 0; i < last; i++) begin
         send_byte(kept[i]);
         if (kept[i] == HDR_BYTE && i < last - 1 &&
             ((!raw && kept[i+1] == STUFF_BYTE) || $urandom_range(0, 99) < stuff_pct))
            send_byte(STUFF_BYTE);
      end
   endtask

   // data bytes lean toward the header and stuffing values
   function automatic logic [7:0] rand_data_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 12) return HDR_BYTE;
      if (r < 20) return STUFF_BYTE;
      return 8'($urandom_range(0, 255));
   endfunction

   // lower valid, wait for every predicted result, then let the pipe settle
   task automatic drain_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // register port
   // ------------------------------------------------------------------

   task automatic csr_read(output logic [31:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= MAX_LEN_ADDR;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      data = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // write the limit, mirror it in the shadow state, read it back
   task automatic set_max_len(input logic [15:0] value);
      logic [31:0] rd;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= MAX_LEN_ADDR;
      csr_pwdata  <= {16'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      st_max_len = value;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_read(rd);
      check_field("max_payload_len", {16'd0, value}, rd);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   task automatic test_reset_value();
      logic [31:0] rd;
      csr_read(rd);
      check_field("max_payload_len", {16'd0, MAX_LEN_RESET}, rd);
   endtask

   // non-0xff while hunting for the header, first and second position
   task automatic test_header_faults();
      send_byte(8'h00);
      send_byte(HDR_BYTE);
      send_byte(8'h7E);
      send_byte(STUFF_BYTE);
      drain_results();
   endtask

   task automatic test_good_frames();
      logic [7:0] none[$];
      logic [7:0] pay[$];
      // zero payload: checksum right after the flags, 0xff fields stuffed
      send_frame(16'd5, 8'h00, 8'hFF, 16'hFFFF, none, 1'b0, 1'b0, 100, -1);
      // payload extremes, including 0xff 0x55 pairs that need stuffing
      pay = '{8'h00, 8'hFF, 8'h55, 8'hFF, 8'hFF, 8'h55, 8'h80, 8'h7F};
      send_frame(16'(pay.size() + 5), 8'hFF, 8'h00, 16'h0000, pay, 1'b0, 1'b0, 100, -1);
      // bad checksum
      pay = '{8'h12, 8'h34};
      send_frame(16'd7, 8'hA5, 8'h5A, 16'h8001, pay, 1'b1, 1'b0, 0, -1);
      drain_results();
   endtask

   task automatic test_length_limits();
      logic [7:0] none[$];
      logic [7:0] pay[$];
      // short lengths
      send_frame(16'd0, 8'h00, 8'h00, 16'h0000, none, 1'b0, 1'b0, 0, 2);
      send_frame(16'd4, 8'h00, 8'h00, 16'h0000, none, 1'b0, 1'b0, 0, 2);
      // longest possible field against the reset limit
      send_frame(16'hFFFF, 8'h00, 8'h00, 16'h0000, none, 1'b0, 1'b0, 0, 2);
      drain_results();
      // limit boundary with a tiny limit
      set_max_len(16'd3);
      pay = '{8'h01, 8'h02, 8'h03};
      send_frame(16'd8, 8'h11, 8'h22, 16'h3344, pay, 1'b0, 1'b0, 0, -1);
      send_frame(16'd9, 8'h00, 8'h00, 16'h0000, none, 1'b0, 1'b0, 0, 2);
      drain_results();
      // zero limit: only empty frames pass
      set_max_len(16'd0);
      send_frame(16'd5, 8'h01, 8'h02, 16'h0304, none, 1'b0, 1'b0, 0, -1);
      send_frame(16'd6, 8'h00, 8'h00, 16'h0000, none, 1'b0, 1'b0, 0, 2);
      drain_results();
      // highest limit: only short lengths fail
      set_max_len(16'd65530);
      send_frame(16'd3, 8'h00, 8'h00, 16'h0000, none, 1'b0, 1'b0, 0, 2);
      pay = '{8'hFF, 8'hFE};
      send_frame(16'd7, 8'h5A, 8'hC3, 16'hFF55, pay, 1'b0, 1'b0, 50, -1);
      drain_results();
      set_max_len(MAX_LEN_RESET);
   endtask

   task automatic test_stuffing();
      logic [7:0] none[$];
      logic [7:0] pay[$];
      // drop inside the length: ff 55 05 reads as 0xff05, too long
      send_byte(HDR_BYTE);
      send_byte(HDR_BYTE);
      send_byte(HDR_BYTE);
      send_byte(STUFF_BYTE);
      send_byte(8'h05);
      // 0x55 right after the header is a length byte, not stuffing
      send_byte(HDR_BYTE);
      send_byte(HDR_BYTE);
      send_byte(STUFF_BYTE);
      send_byte(8'h00);
      // checksum of 0x55 after a 0xff payload byte: stuffed checksum
      pay = '{8'hFF};
      send_frame(16'd6, 8'h50, 8'h00, 16'h0000, pay, 1'b0, 1'b0, 0, -1);
      // unstuffed pair: the data 0x55 is swallowed and the frame slips
      pay = '{8'hFF, 8'h55, 8'h10};
      send_frame(16'd7, 8'h01, 8'h01, 16'h0000, pay, 1'b0, 1'b1, 0, -1);
      // ff 55 55: the second 0x55 is kept since the drop clears the pairing
      pay = '{8'hFF, 8'h55, 8'h55};
      send_frame(16'd8, 8'h02, 8'h03, 16'h0000, pay, 1'b0, 1'b0, 100, -1);
      // stuffed byte directly after the first length byte
      send_frame(16'hFF00, 8'h00, 8'h00, 16'h0000, none, 1'b0, 1'b0, 100, 2);
      drain_results();
   endtask

   // receiver holds off long while the sender keeps offering a frame
   task automatic test_output_stall();
      logic [7:0] pay[$];
      req_gaps_on = 1'b0;
      for (int i = 0; i < 40; i++) pay.push_back(rand_data_byte());
      hold_request = 300;
      send_frame(16'(pay.size() + 5), 8'h77, 8'h88, 16'h1234, pay, 1'b0, 1'b0, 30, -1);
      drain_results();
      req_gaps_on = 1'b1;
   endtask

   // one random stimulus unit: mostly whole frames, some faults and noise;
   // clean keeps the parser aligned, for large limits
   task automatic random_frame(input bit clean);
      logic [7:0]  pay[$];
      logic [15:0] lenf;
      int          n;
      int          r;
      int          top;
      r = clean ? $urandom_range(0, 79) : $urandom_range(0, 99);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
      for (int i = 0; i < n; i++) pay.push_back(rand_data_byte());
      lenf = 16'(n + 5);
      if (r < 72) begin
         send_frame(lenf, rand_data_byte(), rand_data_byte(),
                    {rand_data_byte(), rand_data_byte()}, pay,
                    $urandom_range(0, 99) < 12, 1'b0, 30, -1);
      end else if (r < 80) begin
         // length fault, short or above the current limit
         if (st_max_len >= 16'd65530 || $urandom_range(0, 2) == 0) begin
            lenf = 16'($urandom_range(0, 4));
         end else begin
            top  = 65530 - int'(st_max_len);
            lenf = st_max_len + LEN_OVERHEAD +
                   16'($urandom_range(0, 1) ? $urandom_range(1, (top < 8) ? top : 8)
                                            : $urandom_range(1, top));
         end
         send_frame(lenf, 8'h00, 8'h00, 16'h0000, pay, 1'b0, 1'b0, 30, 2);
      end else if (r < 87) begin
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else if (r < 94) begin
         // truncated frame, the next bytes land in the middle of it
         send_frame(lenf, rand_data_byte(), rand_data_byte(), 16'($urandom_range(0, 65535)),
                    pay, 1'b0, 1'b0, 30, $urandom_range(1, n + 6));
      end else begin
         send_frame(lenf, rand_data_byte(), rand_data_byte(), 16'($urandom_range(0, 65535)),
                    pay, 1'b0, 1'b1, 0, -1);
      end
   endtask

   task automatic random_phase(input logic [15:0] limit, input int n_bytes, input bit clean,
                               input bit req_gaps, input bit rsp_gaps);
      int start;
      drain_results();
      set_max_len(limit);
      req_gaps_on = req_gaps;
      rsp_gaps_on = rsp_gaps;
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) random_frame(clean);
      drain_results();
   endtask

   task automatic test_random();
      random_phase(MAX_LEN_RESET, 280, 1'b0, 1'b1, 1'b1);
      random_phase(16'($urandom_range(1, 20)), 230, 1'b0, 1'b0, 1'b0);
      random_phase(16'd0, 120, 1'b0, 1'b1, 1'b0);
      random_phase(16'($urandom_range(21, 400)), 230, 1'b0, 1'b0, 1'b1);
      random_phase(16'd65530, 120, 1'b1, 1'b1, 1'b1);
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------

   initial begin : main_sequence
      reset          <= 1'b1;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      req_ch.valid   <= 1'b0;
      req_ch.rx_byte <= '0;
      clear_parser();
      st_max_len = MAX_LEN_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_value();
      test_header_faults();
      test_good_frames();
      test_length_limits();
      test_stuffing();
      test_output_stall();
      test_random();

      drain_results();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("serial_frame_deframer_tb passed");
      end else begin
         $display("serial_frame_deframer_tb failed");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin : watchdog
      #5_000_000;
      $display("serial_frame_deframer_tb failed");
      $finish;
   end

endmodule
